// ----- sv/lpol_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lpol_pkg: shared types and constants for the prefix/owner lookup core
// Command codes, status codes and widths.
// ----------------------------------------------------------------------------
package lpol_pkg;

   localparam int PrefixEntriesDefault = 64;
   localparam int OwnerEntriesDefault  = 32;
   localparam int NumInterfacesDefault = 32;

   localparam logic [2:0] CMD_LOOKUP      = 3'd0;
   localparam logic [2:0] CMD_ADD         = 3'd1;
   localparam logic [2:0] CMD_REMOVE      = 3'd2;
   localparam logic [2:0] CMD_SET_OWNER   = 3'd3;
   localparam logic [2:0] CMD_CLR_OWNERS  = 3'd4;
   localparam logic [2:0] CMD_CLR_PREFIX  = 3'd5;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_NOROUTE = 2'd1;
   localparam logic [1:0] ST_FULL    = 2'd2;

   // request tdata, highest bit first
   typedef struct packed {
      logic [5:0]  required_if;
      logic [31:0] gateway;
      logic [4:0]  if_index;
      logic [31:0] metric;
      logic [63:0] owner_id;
      logic [1:0]  owner_kind;
      logic [5:0]  prefix_len;
      logic [31:0] address;
      logic [2:0]  cmd;
   } req_type;

   typedef struct packed {
      logic [31:0] total_metric;
      logic [4:0]  out_if;
      logic [31:0] next_hop;
      logic [5:0]  match_len;
      logic [31:0] network;
      logic [1:0]  status;
   } rsp_type;

   function automatic logic [31:0] len_mask(input logic [5:0] len);
      logic [31:0] m;
      m = '0;
      for (int i = 0; i < 32; i++) begin
         if (32 - i <= int'(len)) m[i] = 1'b1;
      end
      return m;
   endfunction

endpackage
`default_nettype wire

// ----- sv/longest_prefix_owner_lookup_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// longest_prefix_owner_lookup_core
// IPv4 longest-prefix lookup with owner indirection and a command interface.
// ----------------------------------------------------------------------------
// One request beat at a time. The prefix table is a memory with a registered
// read, so every prefix entry is handled in an address state, then a check
// state. Lookup: each prefix entry that matches at a length not below the best
// so far starts an owner scan, which stops on the owner hit or after the last
// owner entry.
// Add, remove: a full prefix pass; add ends early when it finds a duplicate.
// Set owner: a scan of the owner table that stops on a hit. Clears and unused
// commands go straight to completion.
// The result sits in an output register. The core is not ready while busy or
// while a result waits. After the result beat is taken, the core returns to
// idle, where the next request beat can be accepted.
module longest_prefix_owner_lookup_core #(
   parameter int PREFIX_ENTRIES = lpol_pkg::PrefixEntriesDefault,
   parameter int OWNER_ENTRIES  = lpol_pkg::OwnerEntriesDefault,
   parameter int NUM_INTERFACES = lpol_pkg::NumInterfacesDefault
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // cmd, address, prefix_len, owner_kind, owner_id, metric, if_index,
   // gateway, required_if; padded to 184 bits
   input  wire logic [183:0] req_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // status, network, match_len, next_hop, out_if, total_metric; 112 bits
   output logic [111:0]      rsp_tdata,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [31:0]  csr_data
);
   import lpol_pkg::*;

   localparam int PW = $clog2(PREFIX_ENTRIES);
   localparam int OW = $clog2(OWNER_ENTRIES);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_PSCAN = 3'd1;   // prefix pass, read address
   localparam logic [2:0] S_OSCAN = 3'd2;   // owner pass
   localparam logic [2:0] S_DONE = 3'd3;
   localparam logic [2:0] S_OUT = 3'd4;
   localparam logic [2:0] S_PCHK = 3'd5;    // prefix pass, check read data

   logic [2:0]  state_ff;
   req_type     rq_ff;
   logic [31:0] up_ff;
   logic [PW:0] pi_ff;
   logic [OW:0] oi_ff;
   rsp_type     rsp_ff;
   rsp_type     rsp_in;

   logic [PREFIX_ENTRIES-1:0] pv_ff;
   logic [31:0]       pnet_ff [PREFIX_ENTRIES];
   logic [5:0]        plen_ff [PREFIX_ENTRIES];
   logic [1:0]        pkind_ff [PREFIX_ENTRIES];
   logic [63:0]       pid_ff [PREFIX_ENTRIES];
   logic [31:0]       pmet_ff [PREFIX_ENTRIES];
   logic              ov_ff [OWNER_ENTRIES];
   logic [1:0]        okind_ff [OWNER_ENTRIES];
   logic [63:0]       oid_ff [OWNER_ENTRIES];
   logic [4:0]        oif_ff [OWNER_ENTRIES];
   logic [31:0]       onh_ff [OWNER_ENTRIES];
   logic [31:0]       omet_ff [OWNER_ENTRIES];

   // registered read of the prefix entry at pidx
   logic [31:0]       pe_net_ff;
   logic [5:0]        pe_len_ff;
   logic [1:0]        pe_kind_ff;
   logic [63:0]       pe_id_ff;
   logic [31:0]       pe_met_ff;

   // best candidate so far
   logic              found_ff;
   logic [5:0]        blen_ff;
   logic [31:0]       bnet_ff, bmet_ff, bnh_ff;
   logic [1:0]        bkind_ff;
   logic [63:0]       bid_ff;
   logic [4:0]        bif_ff;
   // add/set bookkeeping
   logic              free_ok_ff;
   logic [PW-1:0]     free_p_ff;
   logic [OW-1:0]     free_o_ff;
   logic              hit_ff;
   logic [OW-1:0]     hit_o_ff;

   req_type in_req;
   assign in_req = req_type'(req_tdata[181:0]);

   logic [5:0]  add_len;
   logic [31:0] add_net;
   logic [PW-1:0] pidx;
   logic [OW-1:0] oidx;
   assign add_len = (rq_ff.prefix_len > 6'd32) ? 6'd32 : rq_ff.prefix_len;
   assign add_net = rq_ff.address & len_mask(add_len);
   assign pidx = pi_ff[PW-1:0];
   assign oidx = oi_ff[OW-1:0];

   // current prefix entry matches destination at its own length, not below the best so far
   logic p_match;
   assign p_match = pv_ff[pidx] &&
      ((rq_ff.address & len_mask(pe_len_ff)) == pe_net_ff) &&
      (pe_len_ff <= 6'd32) &&
      (!found_ff || pe_len_ff >= blen_ff);

   // add: same masked network, length and owner already stored
   logic add_hit;
   assign add_hit = pv_ff[pidx] && pe_net_ff == add_net && pe_len_ff == add_len &&
                    pe_kind_ff == rq_ff.owner_kind && pe_id_ff == rq_ff.owner_id;

   // prefix store writes: new entry at the end of an add, metric lowering on
   // a duplicate during the pass
   logic pmem_wr, pmet_upd;
   assign pmem_wr = (state_ff == S_DONE) && (rq_ff.cmd == CMD_ADD) && !hit_ff &&
                    free_ok_ff;
   assign pmet_upd = (state_ff == S_PCHK) && (rq_ff.cmd == CMD_ADD) && add_hit &&
                     (rq_ff.metric < pe_met_ff);

   // owner side for the prefix being resolved
   logic        o_hit, o_use;
   logic [31:0] o_total;
   logic        better;
   assign o_hit = ov_ff[oidx] && okind_ff[oidx] == pe_kind_ff &&
                  oid_ff[oidx] == pe_id_ff;
   assign o_use = (int'(oif_ff[oidx]) < NUM_INTERFACES) && up_ff[oif_ff[oidx]] &&
                  (rq_ff.required_if[5] || oif_ff[oidx] == rq_ff.required_if[4:0]);
   assign o_total = omet_ff[oidx] + pe_met_ff;
   assign better = !found_ff || pe_len_ff > blen_ff || o_total < bmet_ff ||
      (o_total == bmet_ff && (pe_kind_ff < bkind_ff ||
       (pe_kind_ff == bkind_ff && pe_id_ff < bid_ff)));

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_OUT);
   assign rsp_tdata  = {3'b000, rsp_ff};

   // result beat for the finished command
   always_comb begin
      rsp_in = '0;
      unique case (rq_ff.cmd)
         CMD_LOOKUP: begin
            if (found_ff) begin
               rsp_in.status       = ST_OK;
               rsp_in.network      = bnet_ff;
               rsp_in.match_len    = blen_ff;
               rsp_in.next_hop     = bnh_ff;
               rsp_in.out_if       = bif_ff;
               rsp_in.total_metric = bmet_ff;
            end else rsp_in.status = ST_NOROUTE;
         end
         CMD_ADD, CMD_SET_OWNER: begin
            if (!hit_ff && !free_ok_ff) rsp_in.status = ST_FULL;
         end
         default: ;
      endcase
   end

   // prefix data store: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (pmem_wr) begin
         pnet_ff[free_p_ff]  <= add_net;
         plen_ff[free_p_ff]  <= add_len;
         pkind_ff[free_p_ff] <= rq_ff.owner_kind;
         pid_ff[free_p_ff]   <= rq_ff.owner_id;
      end
      if (pmem_wr || pmet_upd) pmet_ff[pmem_wr ? free_p_ff : pidx] <= rq_ff.metric;
      pe_net_ff  <= pnet_ff[pidx];
      pe_len_ff  <= plen_ff[pidx];
      pe_kind_ff <= pkind_ff[pidx];
      pe_id_ff   <= pid_ff[pidx];
      pe_met_ff  <= pmet_ff[pidx];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         up_ff    <= '0;
         rq_ff    <= '0;
         pv_ff    <= '0;
         for (int i = 0; i < OWNER_ENTRIES; i++) ov_ff[i] <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (csr_valid) up_ff <= csr_data;
               if (req_tvalid) begin
                  rq_ff      <= in_req;
                  pi_ff      <= '0;
                  oi_ff      <= '0;
                  found_ff   <= 1'b0;
                  free_ok_ff <= 1'b0;
                  hit_ff     <= 1'b0;
                  unique case (in_req.cmd)
                     CMD_LOOKUP, CMD_ADD, CMD_REMOVE: state_ff <= S_PSCAN;
                     CMD_SET_OWNER: state_ff <= S_OSCAN;
                     default: state_ff <= S_DONE;
                  endcase
               end
            end
            S_PSCAN: begin
               // entry pidx lands in the pe_*_ff registers at this edge
               if (pi_ff == (PW+1)'(PREFIX_ENTRIES)) state_ff <= S_DONE;
               else state_ff <= S_PCHK;
            end
            S_PCHK: begin
               priority case (rq_ff.cmd)
                  CMD_LOOKUP: begin
                     if (p_match) begin
                        oi_ff    <= '0;
                        state_ff <= S_OSCAN;
                     end else begin
                        pi_ff    <= pi_ff + 1'b1;
                        state_ff <= S_PSCAN;
                     end
                  end
                  CMD_REMOVE: begin
                     if (pv_ff[pidx] && pe_kind_ff == rq_ff.owner_kind &&
                         pe_id_ff == rq_ff.owner_id) pv_ff[pidx] <= 1'b0;
                     pi_ff    <= pi_ff + 1'b1;
                     state_ff <= S_PSCAN;
                  end
                  default: begin
                     // duplicate: metric lowered by the store write port
                     if (add_hit) begin
                        hit_ff   <= 1'b1;
                        state_ff <= S_DONE;
                     end else begin
                        pi_ff    <= pi_ff + 1'b1;
                        state_ff <= S_PSCAN;
                        if (!pv_ff[pidx] && !free_ok_ff) begin
                           free_ok_ff <= 1'b1;
                           free_p_ff  <= pidx;
                        end
                     end
                  end
               endcase
            end
            S_OSCAN: begin
               if (rq_ff.cmd == CMD_LOOKUP) begin
                  if (o_hit || oi_ff == (OW+1)'(OWNER_ENTRIES - 1)) begin
                     if (o_hit && o_use && better) begin
                        found_ff <= 1'b1;
                        blen_ff  <= pe_len_ff;
                        bnet_ff  <= pe_net_ff;
                        bmet_ff  <= o_total;
                        bkind_ff <= pe_kind_ff;
                        bid_ff   <= pe_id_ff;
                        bnh_ff   <= onh_ff[oidx];
                        bif_ff   <= oif_ff[oidx];
                     end
                     pi_ff    <= pi_ff + 1'b1;
                     state_ff <= S_PSCAN;
                  end else oi_ff <= oi_ff + 1'b1;
               end else begin
                  if (oi_ff == (OW+1)'(OWNER_ENTRIES)) begin
                     state_ff <= S_DONE;
                  end else begin
                     oi_ff <= oi_ff + 1'b1;
                     if (ov_ff[oidx] && okind_ff[oidx] == rq_ff.owner_kind &&
                         oid_ff[oidx] == rq_ff.owner_id) begin
                        hit_ff   <= 1'b1;
                        hit_o_ff <= oidx;
                        state_ff <= S_DONE;
                     end else if (!ov_ff[oidx] && !free_ok_ff) begin
                        free_ok_ff <= 1'b1;
                        free_o_ff  <= oidx;
                     end
                  end
               end
            end
            S_DONE: begin
               rsp_ff   <= rsp_in;
               state_ff <= S_OUT;
               unique case (rq_ff.cmd)
                  CMD_ADD: begin
                     if (!hit_ff && free_ok_ff) pv_ff[free_p_ff] <= 1'b1;
                  end
                  CMD_SET_OWNER: begin
                     if (hit_ff || free_ok_ff) begin
                        ov_ff[hit_ff ? hit_o_ff : free_o_ff]    <= 1'b1;
                        okind_ff[hit_ff ? hit_o_ff : free_o_ff] <= rq_ff.owner_kind;
                        oid_ff[hit_ff ? hit_o_ff : free_o_ff]   <= rq_ff.owner_id;
                        oif_ff[hit_ff ? hit_o_ff : free_o_ff]   <= rq_ff.if_index;
                        onh_ff[hit_ff ? hit_o_ff : free_o_ff]   <= rq_ff.gateway;
                        omet_ff[hit_ff ? hit_o_ff : free_o_ff]  <= rq_ff.metric;
                     end
                  end
                  CMD_CLR_OWNERS:
                     for (int i = 0; i < OWNER_ENTRIES; i++) ov_ff[i] <= 1'b0;
                  CMD_CLR_PREFIX: pv_ff <= '0;
                  default: ;
               endcase
            end
            S_OUT: if (rsp_tready) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // result only ever shown after a completed command
   a_out_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff) == S_DONE)
      else $error("result without completion");
   // request and config side closed while a result waits
   a_closed: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready && !csr_ready)
      else $error("input open while busy");
   // length of the best candidate never exceeds 32
   a_len: assert property (@(posedge clock) disable iff (reset)
      found_ff && state_ff != S_IDLE |-> blen_ff <= 6'd32)
      else $error("bad match length");

endmodule
`default_nettype wire
